[rtl/assert_macros.svh]
// Assertion macros used by scanline_irq_detector.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SID_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scanline_irq_detector assertion failed");
`define SID_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scanline_irq_detector assertion failed");
`else
`define SID_ASSERT(lbl, clk, rst_n, prop)
`define SID_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/sid_pkg.sv]
package sid_pkg;

  typedef enum logic [1:0] {
    ACT_VIDEO_READ = 2'd0,
    ACT_CPU_TICK   = 2'd1,
    ACT_CPU_WRITE  = 2'd2,
    ACT_CPU_READ   = 2'd3
  } sid_action_e;

  localparam logic [15:0] ADDR_TARGET = 16'h5203;
  localparam logic [15:0] ADDR_STATUS = 16'h5204;
  localparam logic [15:0] ADDR_NMI_LO = 16'hFFFA;
  localparam logic [15:0] ADDR_NMI_HI = 16'hFFFB;
  localparam logic [15:0] NT_LOW      = 16'h2000;
  localparam logic [15:0] NT_HIGH     = 16'h3000;
  localparam logic [1:0]  REPEAT_ARM  = 2'd3;
  localparam logic [1:0]  IDLE_LIMIT  = 2'd3;

  typedef struct packed {
    sid_action_e action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } sid_item_t;

  typedef struct packed {
    logic       irq_line;
    logic [7:0] read_data;
    logic       frame_active;
  } sid_result_t;

  typedef struct packed {
    logic       framing;
    logic       status;
    logic       enable;
    logic [7:0] line_count;
  } sid_state_t;

endpackage

[rtl/sid_item_if.sv]
interface sid_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output action, output address, output write_data,
                  input ready);
  modport sink (input valid, input action, input address, input write_data,
                output ready);
endinterface

[rtl/sid_result_if.sv]
interface sid_result_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [7:0] read_data;
  logic       frame_active;

  modport source (output valid, output irq_line, output read_data, output frame_active,
                  input ready);
  modport sink (input valid, input irq_line, input read_data, input frame_active,
                output ready);
endinterface

[rtl/sid_in_stage.sv]
module sid_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  sid_item_if.sink            item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output sid_pkg::sid_item_t  item_o
);

  logic               valid_q, valid_d;
  sid_pkg::sid_item_t item_q, item_d;
  logic               take;

  assign item_i.ready = !valid_q || advance_i;
  assign take         = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d            = 1'b1;
      item_d.action      = sid_pkg::sid_action_e'(item_i.action);
      item_d.address     = item_i.address;
      item_d.write_data  = item_i.write_data;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/sid_core.sv]
module sid_core #(
  parameter int LINES_PER_FRAME = 240
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  sid_pkg::sid_item_t    item_i,
  output sid_pkg::sid_result_t  result_o,
  output sid_pkg::sid_state_t   state_o
);

  localparam logic [7:0] LastLine = 8'(LINES_PER_FRAME);

  logic        framing_q, framing_d;
  logic [7:0]  line_q, line_d;
  logic [1:0]  repeat_q, repeat_d;
  logic [15:0] prev_q, prev_d;
  logic        seen_q, seen_d;
  logic [1:0]  idle_q, idle_d;
  logic        status_q, status_d;
  logic        enable_q, enable_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  read_data;
  logic [7:0]  line_inc;
  logic [1:0]  repeat_base;
  logic        in_nt;

  assign line_inc = line_q + 8'd1;
  assign in_nt    = (item_i.address >= sid_pkg::NT_LOW) && (item_i.address < sid_pkg::NT_HIGH);

  always_comb begin
    framing_d   = framing_q;
    line_d      = line_q;
    repeat_d    = repeat_q;
    prev_d      = prev_q;
    seen_d      = seen_q;
    idle_d      = idle_q;
    status_d    = status_q;
    enable_d    = enable_q;
    target_d    = target_q;
    read_data   = 8'd0;
    repeat_base = repeat_q;
    case (item_i.action)
      sid_pkg::ACT_VIDEO_READ: begin
        seen_d = 1'b1;
        if (repeat_q == sid_pkg::REPEAT_ARM) begin
          repeat_base = 2'd0;
          if (!framing_q) begin
            framing_d = 1'b1;
            line_d    = 8'd0;
            status_d  = 1'b0;
          end else if (line_inc == LastLine) begin
            framing_d = 1'b0;
            line_d    = 8'd0;
            status_d  = 1'b0;
          end else begin
            line_d = line_inc;
            if (target_q != 8'd0 && line_inc == target_q) begin
              status_d = 1'b1;
            end
          end
        end
        if (in_nt) begin
          repeat_d = (item_i.address == prev_q) ? repeat_base + 2'd1 : 2'd1;
        end else begin
          repeat_d = 2'd0;
        end
        prev_d = item_i.address;
      end
      sid_pkg::ACT_CPU_TICK: begin
        if (seen_q) begin
          idle_d = 2'd0;
          seen_d = 1'b0;
        end else if (idle_q != sid_pkg::IDLE_LIMIT) begin
          idle_d = idle_q + 2'd1;
          if (idle_d == sid_pkg::IDLE_LIMIT) begin
            framing_d = 1'b0;
            repeat_d  = 2'd0;
          end
        end
      end
      sid_pkg::ACT_CPU_WRITE: begin
        if (item_i.address == sid_pkg::ADDR_TARGET) begin
          target_d = item_i.write_data;
        end else if (item_i.address == sid_pkg::ADDR_STATUS) begin
          enable_d = item_i.write_data[7];
        end
      end
      sid_pkg::ACT_CPU_READ: begin
        if (item_i.address == sid_pkg::ADDR_STATUS) begin
          read_data = {status_q, framing_q, 6'd0};
          status_d  = 1'b0;
        end else if (item_i.address == sid_pkg::ADDR_NMI_LO ||
                     item_i.address == sid_pkg::ADDR_NMI_HI) begin
          framing_d = 1'b0;
          line_d    = 8'd0;
          repeat_d  = 2'd0;
          status_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framing_q <= 1'b0;
      line_q    <= 8'd0;
      repeat_q  <= 2'd0;
      prev_q    <= 16'd0;
      seen_q    <= 1'b0;
      idle_q    <= 2'd0;
      status_q  <= 1'b0;
      enable_q  <= 1'b0;
      target_q  <= 8'd0;
    end else if (fire_i) begin
      framing_q <= framing_d;
      line_q    <= line_d;
      repeat_q  <= repeat_d;
      prev_q    <= prev_d;
      seen_q    <= seen_d;
      idle_q    <= idle_d;
      status_q  <= status_d;
      enable_q  <= enable_d;
      target_q  <= target_d;
    end
  end

  assign result_o.irq_line     = enable_d && status_d;
  assign result_o.read_data    = read_data;
  assign result_o.frame_active = framing_d;

  assign state_o.framing    = framing_q;
  assign state_o.status     = status_q;
  assign state_o.enable     = enable_q;
  assign state_o.line_count = line_q;

endmodule

[rtl/sid_out_stage.sv]
module sid_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sid_pkg::sid_result_t  result_i,
  output logic                  advance_o,
  sid_result_if.source          result_o
);

  logic                 valid_q, valid_d;
  sid_pkg::sid_result_t data_q;

  assign advance_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.irq_line     = data_q.irq_line;
  assign result_o.read_data    = data_q.read_data;
  assign result_o.frame_active = data_q.frame_active;

endmodule

[rtl/scanline_irq_detector.sv]
// Scanline IRQ detector. Words arrive on item_i: a video bus read, a CPU cycle
// tick, a CPU write or a CPU read, with address and write data. Every input word
// yields exactly one result word on result_o carrying the IRQ line, the read data
// of a status read and the in-frame flag, all as they stand after that word.
// A word is registered at the input, the counter state is updated by one short
// pass of compares and increments, and the result is registered at the output.
// One word is taken every cycle while the receiver keeps result_o.ready high;
// the rate is set by the state update loop.
// When the receiver stalls, the result register holds its word and the input
// register keeps the next one, so item_i.ready drops only while both are full.
// No word is lost or repeated across a stall.
// Reset clears the frame state, counters, target, enable and status, and empties
// both registers; item_i.ready is high as soon as reset is released.
`include "assert_macros.svh"

module scanline_irq_detector #(
  parameter int LINES_PER_FRAME = 240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sid_item_if.sink      item_i,
  sid_result_if.source  result_o
);

  logic                 s1_valid;
  sid_pkg::sid_item_t   s1_item;
  logic                 advance;
  logic                 fire;
  sid_pkg::sid_result_t core_result;
  sid_pkg::sid_state_t  core_state;

  assign fire = s1_valid && advance;

  sid_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  sid_core #(
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .result_o (core_result),
    .state_o  (core_state)
  );

  sid_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .result_i  (core_result),
    .advance_o (advance),
    .result_o  (result_o)
  );

  `SID_ASSERT(a_fire_fills_output, clk_i, rst_ni, fire |=> result_o.valid)
  `SID_ASSERT(a_frame_matches_state, clk_i, rst_ni,
              fire |=> (result_o.frame_active == core_state.framing))
  `SID_ASSERT(a_irq_matches_state, clk_i, rst_ni,
              fire |=> (result_o.irq_line == (core_state.enable && core_state.status)))
  `SID_ASSERT_ALWAYS(a_line_in_range, clk_i,
                     !rst_ni || (core_state.line_count < 8'(LINES_PER_FRAME)))

endmodule
